// File: hw/rtl/bdsa_pkg.sv
package bdsa_pkg;

  // Register field widths
  localparam int RATE_BITS    = 4;
  localparam int DIM_BITS     = 11;
  localparam int ROW_BITS     = 10;
  localparam int OUT_COL_BITS = 10;
  localparam int ADDR_BITS    = 4;
  localparam int DATA_BITS    = 32;

  // Register reset values
  localparam logic [RATE_BITS-1:0] RATE_RESET   = 4'd2;
  localparam logic [DIM_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [DIM_BITS-1:0]  HEIGHT_RESET = 11'd480;

  // Largest usable output height
  localparam logic [DIM_BITS-1:0] HEIGHT_LIMIT = 11'd1024;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_RATE   = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2
  } reg_idx_t;

  // Per-request control carried down the pipeline
  typedef struct packed {
    logic first;
    logic emit;
    logic row_end;
    logic frame_end;
  } ctl_t;

endpackage

// File: hw/rtl/box_downsample_average_unit.sv
// Box-filter downsampler for a supersampled RGB stream.
// Input channel: in_valid / in_stall with red_in, green_in, blue_in, one sample
// per request, raster order over an image N*out_width by N*out_height samples.
// Output channel: out_valid / out_stall with red_avg, green_avg, blue_avg,
// out_column, row_end and frame_end, one pixel per completed N-by-N block.
// Configuration: APB-style port, sampling_rate at 0x0, out_width at 0x4,
// out_height at 0x8; write only while the block is idle.
// Throughput: one sample per cycle while in_stall is low. Per-column sums
// live in one synchronous memory; each sample reads its column, adds, and
// writes back from stage 1, with the just-written sum forwarded when the next
// sample hits the same column. Path to out_valid: memory read, accumulate,
// reciprocal multiply, output register.
// Reset: counters return to the frame origin and registers to their defaults;
// the sum memory is not cleared, since each block's first sample overwrites it.
// Stall: a held result stays on the output; earlier stages keep filling empty
// slots, and in_stall rises once every stage holds a request.
module box_downsample_average_unit #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_RATE    = 8,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // sample channel
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [SAMPLE_BITS-1:0]                red_in,
  input  logic [SAMPLE_BITS-1:0]                green_in,
  input  logic [SAMPLE_BITS-1:0]                blue_in,
  // pixel channel
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [SAMPLE_BITS-1:0]                red_avg,
  output logic [SAMPLE_BITS-1:0]                green_avg,
  output logic [SAMPLE_BITS-1:0]                blue_avg,
  output logic [bdsa_pkg::OUT_COL_BITS-1:0]     out_column,
  output logic                                  row_end,
  output logic                                  frame_end,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [bdsa_pkg::ADDR_BITS-1:0]        paddr,
  input  logic [bdsa_pkg::DATA_BITS-1:0]        pwdata,
  output logic [bdsa_pkg::DATA_BITS-1:0]        prdata,
  output logic                                  pready
);

  localparam int RATE_BITS = bdsa_pkg::RATE_BITS;
  localparam int DIM_BITS  = bdsa_pkg::DIM_BITS;
  localparam int ROW_BITS  = bdsa_pkg::ROW_BITS;
  localparam int SUB_W     = (MAX_RATE > 2) ? $clog2(MAX_RATE) : 1;
  localparam int COL_W     = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
  localparam int AREA_W    = (MAX_RATE > 1) ? $clog2(MAX_RATE * MAX_RATE) : 1;
  localparam int SUM_W     = SAMPLE_BITS + AREA_W;
  localparam int SHIFT     = SUM_W + AREA_W;
  localparam int RECIP_W   = SHIFT + 1;
  localparam int PROD_W    = SUM_W + RECIP_W;
  localparam int WORD_W    = 3 * SUM_W;
  localparam int RCMP_W    = RATE_BITS + 1;
  localparam int WLIM_W    = $clog2(MAX_WIDTH + 1);
  localparam int DCMP_W    = (WLIM_W > DIM_BITS) ? WLIM_W : DIM_BITS;
  localparam int COLX_W    = (COL_W > bdsa_pkg::OUT_COL_BITS) ? COL_W
                                                              : bdsa_pkg::OUT_COL_BITS;
  localparam int RATE_N    = 2 ** RATE_BITS;

  // Configuration registers
  logic [RATE_BITS-1:0] sampling_rate;
  logic [DIM_BITS-1:0]  out_width;
  logic [DIM_BITS-1:0]  out_height;

  // Position counters
  logic [SUB_W-1:0]    sub_column;
  logic [SUB_W-1:0]    sub_row;
  logic [COL_W-1:0]    block_column;
  logic [ROW_BITS-1:0] block_row;

  // Pipeline registers
  logic                   s1_valid;
  bdsa_pkg::ctl_t         s1_ctl;
  logic [COL_W-1:0]       s1_col;
  logic [3*SAMPLE_BITS-1:0] s1_smp;
  logic                   s1_fwd;
  logic [WORD_W-1:0]      fwd_sum;
  logic [WORD_W-1:0]      mem_rdata;
  logic                   s2_valid;
  bdsa_pkg::ctl_t         s2_ctl;
  logic [COL_W-1:0]       s2_col;
  logic [WORD_W-1:0]      s2_sum;
  logic                   s3_valid;
  bdsa_pkg::ctl_t         s3_ctl;
  logic [COL_W-1:0]       s3_col;
  logic [PROD_W-1:0]      s3_prod [3];

  // Column sum memory
  logic [WORD_W-1:0] sum_mem [MAX_WIDTH];

  logic en_out, en3, en2, en1, in_acc, cfg_wr;
  logic [RATE_BITS-1:0] rate_wr;
  logic [DCMP_W-1:0]    w_eff, h_eff;
  logic [DCMP_W-1:0]    col_inc, row_inc;
  logic [RCMP_W-1:0]    scol_inc, srow_inc;
  logic last_sub_col, last_sub_row, last_col, last_row;
  logic [WORD_W-1:0]    base_word, sum_word;
  logic [RECIP_W-1:0]   recip_tab [RATE_N];
  logic [RECIP_W-1:0]   recip;
  logic [COLX_W-1:0]    col_ext;

  // Reciprocal of N*N, rounded up, exact for every sum in range
  for (genvar g = 0; g < RATE_N; g++) begin : g_recip
    if (g >= 1 && g <= MAX_RATE) begin : g_on
      localparam longint unsigned D = longint'(g) * longint'(g);
      localparam longint unsigned M = ((64'd1 << SHIFT) + D - 64'd1) / D;
      assign recip_tab[g] = RECIP_W'(M);
    end else begin : g_off
      assign recip_tab[g] = '0;
    end
  end
  assign recip = recip_tab[sampling_rate];

  // Stage enables: a stage moves when the next one is empty or moving
  assign en_out   = !out_valid || !out_stall;
  assign en3      = !s3_valid || en_out;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_stall = !en1;
  assign in_acc   = in_valid && en1;

  // Configuration write and readback
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign rate_wr = pwdata[RATE_BITS-1:0];

  always_comb begin
    prdata = '0;
    unique case (bdsa_pkg::reg_idx_t'(paddr[3:2]))
      bdsa_pkg::REG_RATE:   prdata = bdsa_pkg::DATA_BITS'(sampling_rate);
      bdsa_pkg::REG_WIDTH:  prdata = bdsa_pkg::DATA_BITS'(out_width);
      bdsa_pkg::REG_HEIGHT: prdata = bdsa_pkg::DATA_BITS'(out_height);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sampling_rate <= bdsa_pkg::RATE_RESET;
      out_width     <= bdsa_pkg::WIDTH_RESET;
      out_height    <= bdsa_pkg::HEIGHT_RESET;
    end else if (cfg_wr) begin
      unique case (bdsa_pkg::reg_idx_t'(paddr[3:2]))
        bdsa_pkg::REG_RATE: begin
          // drop a rate outside 1..MAX_RATE
          if (rate_wr != '0 && RCMP_W'(rate_wr) <= RCMP_W'(MAX_RATE)) begin
            sampling_rate <= rate_wr;
          end
        end
        bdsa_pkg::REG_WIDTH:  out_width  <= pwdata[DIM_BITS-1:0];
        bdsa_pkg::REG_HEIGHT: out_height <= pwdata[DIM_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the image size to its usable range
  always_comb begin
    if (out_width == '0) begin
      w_eff = DCMP_W'(1);
    end else if (DCMP_W'(out_width) > DCMP_W'(MAX_WIDTH)) begin
      w_eff = DCMP_W'(MAX_WIDTH);
    end else begin
      w_eff = DCMP_W'(out_width);
    end
    if (out_height == '0) begin
      h_eff = DCMP_W'(1);
    end else if (out_height > bdsa_pkg::HEIGHT_LIMIT) begin
      h_eff = DCMP_W'(bdsa_pkg::HEIGHT_LIMIT);
    end else begin
      h_eff = DCMP_W'(out_height);
    end
  end

  // Position tests for the incoming sample
  assign scol_inc     = RCMP_W'(sub_column) + RCMP_W'(1);
  assign srow_inc     = RCMP_W'(sub_row) + RCMP_W'(1);
  assign col_inc      = DCMP_W'(block_column) + DCMP_W'(1);
  assign row_inc      = DCMP_W'(block_row) + DCMP_W'(1);
  assign last_sub_col = scol_inc >= RCMP_W'(sampling_rate);
  assign last_sub_row = srow_inc >= RCMP_W'(sampling_rate);
  assign last_col     = col_inc >= w_eff;
  assign last_row     = row_inc >= h_eff;

  // Advance the raster counters on each accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      sub_column   <= '0;
      sub_row      <= '0;
      block_column <= '0;
      block_row    <= '0;
    end else if (in_acc) begin
      if (!last_sub_col) begin
        sub_column <= sub_column + SUB_W'(1);
      end else begin
        sub_column <= '0;
        if (!last_col) begin
          block_column <= block_column + COL_W'(1);
        end else begin
          block_column <= '0;
          if (!last_sub_row) begin
            sub_row <= sub_row + SUB_W'(1);
          end else begin
            sub_row <= '0;
            if (!last_row) begin
              block_row <= block_row + ROW_BITS'(1);
            end else begin
              block_row <= '0;
            end
          end
        end
      end
    end
  end

  // Stage 1 control: read issued, request captured
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_ctl.first     <= (sub_row == '0) && (sub_column == '0);
      s1_ctl.emit      <= last_sub_col && last_sub_row;
      s1_ctl.row_end   <= last_col;
      s1_ctl.frame_end <= last_col && last_row;
      s1_col           <= block_column;
      s1_smp           <= {red_in, green_in, blue_in};
      // the sum being written this edge is not yet visible to the read
      s1_fwd           <= s1_valid && (s1_col == block_column);
      fwd_sum          <= sum_word;
    end
  end

  // Memory read and write-back
  always_ff @(posedge clk) begin
    if (in_acc) begin
      mem_rdata <= sum_mem[block_column];
    end
    if (s1_valid && en2) begin
      sum_mem[s1_col] <= sum_word;
    end
  end

  // Accumulate: a block's first sample overwrites, the rest add
  assign base_word = s1_fwd ? fwd_sum : mem_rdata;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      if (s1_ctl.first) begin
        sum_word[c*SUM_W +: SUM_W] = SUM_W'(s1_smp[c*SAMPLE_BITS +: SAMPLE_BITS]);
      end else begin
        sum_word[c*SUM_W +: SUM_W] = base_word[c*SUM_W +: SUM_W]
                                   + SUM_W'(s1_smp[c*SAMPLE_BITS +: SAMPLE_BITS]);
      end
    end
  end

  // Stage 2: keep only block-completing requests
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid && s1_ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_ctl <= s1_ctl;
      s2_col <= s1_col;
      s2_sum <= sum_word;
    end
  end

  // Stage 3: multiply by the reciprocal of the block area
  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_ctl <= s2_ctl;
      s3_col <= s2_col;
      for (int c = 0; c < 3; c++) begin
        s3_prod[c] <= PROD_W'(s2_sum[c*SUM_W +: SUM_W]) * PROD_W'(recip);
      end
    end
  end

  // Output register: hold while stalled
  assign col_ext = COLX_W'(s3_col);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      blue_avg   <= s3_prod[0][SHIFT +: SAMPLE_BITS];
      green_avg  <= s3_prod[1][SHIFT +: SAMPLE_BITS];
      red_avg    <= s3_prod[2][SHIFT +: SAMPLE_BITS];
      out_column <= col_ext[bdsa_pkg::OUT_COL_BITS-1:0];
      row_end    <= s3_ctl.row_end;
      frame_end  <= s3_ctl.frame_end;
    end
  end

endmodule
